@@ src/fqrqs_pkg.sv @@
`default_nettype none

package fqrqs_pkg;

    localparam int MAX_READ_LENGTH_DEF = 65535;
    localparam int TOTAL_BITS_DEF      = 40;

    localparam int BYTE_W   = 8;
    localparam int THRESH_W = 7;
    localparam int SUM_W    = 24;
    localparam int LENGTH_W = 16;
    localparam int COUNT_W  = 32;
    localparam int TOTAL_W  = 40;
    localparam int OUT_W    = 192;

    localparam logic [BYTE_W-1:0]   NEWLINE_BYTE    = 8'd10;
    localparam logic [9:0]          PHRED_OFFSET    = 10'd33;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 7'd30;
    localparam logic [1:0]          QUAL_LINE       = 2'd3;

    localparam logic [SUM_W-1:0] SUM_MAX = 24'h7FFFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 24'h800000;

endpackage

`default_nettype wire

@@ src/fqrqs_parse.sv @@
`default_nettype none

module fqrqs_parse #(
    parameter int MAX_READ_LENGTH = fqrqs_pkg::MAX_READ_LENGTH_DEF,
    parameter int LEN_W           = $clog2(MAX_READ_LENGTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [fqrqs_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                         in_last,
    output logic                              ev_valid,
    input  wire logic                         ev_ready,
    output logic      [fqrqs_pkg::SUM_W-1:0]  ev_sum,
    output logic      [LEN_W-1:0]             ev_len
);

    logic [1:0]                      line_reg, line_next;
    logic [fqrqs_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic                            ev_valid_reg, ev_valid_next;
    logic [fqrqs_pkg::SUM_W-1:0]     ev_sum_reg;
    logic [LEN_W-1:0]                ev_len_reg;

    logic                            accept;
    logic                            is_newline;
    logic                            on_quality;
    logic                            take_byte;
    logic                            close_now;
    logic [9:0]                      delta;
    logic [fqrqs_pkg::SUM_W:0]       sum_wide;
    logic [fqrqs_pkg::SUM_W-1:0]     sum_upd;
    logic [LEN_W-1:0]                len_upd;

    assign in_ready = !ev_valid_reg || ev_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_newline = (in_byte == fqrqs_pkg::NEWLINE_BYTE);
        on_quality = (line_reg == fqrqs_pkg::QUAL_LINE);
        take_byte  = !is_newline && on_quality && (len_reg < LEN_W'(MAX_READ_LENGTH));
        close_now  = (is_newline && on_quality) || in_last;

        delta    = {2'b00, in_byte} - fqrqs_pkg::PHRED_OFFSET;
        sum_wide = {sum_reg[fqrqs_pkg::SUM_W-1], sum_reg}
                 + {{(fqrqs_pkg::SUM_W - 9){delta[9]}}, delta};
        if (sum_wide[fqrqs_pkg::SUM_W] != sum_wide[fqrqs_pkg::SUM_W-1])
        begin
            sum_upd = sum_wide[fqrqs_pkg::SUM_W] ? fqrqs_pkg::SUM_MIN : fqrqs_pkg::SUM_MAX;
        end
        else
        begin
            sum_upd = sum_wide[fqrqs_pkg::SUM_W-1:0];
        end
        len_upd = len_reg + LEN_W'(1);

        if (!take_byte)
        begin
            sum_upd = sum_reg;
            len_upd = len_reg;
        end
    end

    always_comb
    begin
        line_next     = line_reg;
        sum_next      = sum_reg;
        len_next      = len_reg;
        ev_valid_next = ev_ready ? 1'b0 : ev_valid_reg;
        if (accept)
        begin
            if (close_now)
            begin
                line_next     = 2'd0;
                sum_next      = '0;
                len_next      = '0;
                ev_valid_next = 1'b1;
            end
            else
            begin
                line_next = is_newline ? line_reg + 2'd1 : line_reg;
                sum_next  = sum_upd;
                len_next  = len_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg     <= 2'd0;
            sum_reg      <= '0;
            len_reg      <= '0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            line_reg     <= line_next;
            sum_reg      <= sum_next;
            len_reg      <= len_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && close_now)
        begin
            ev_sum_reg <= sum_upd;
            ev_len_reg <= len_upd;
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev_sum   = ev_sum_reg;
    assign ev_len   = ev_len_reg;

endmodule

`default_nettype wire

@@ src/fqrqs_tally.sv @@
`default_nettype none

module fqrqs_tally #(
    parameter int LEN_W      = 16,
    parameter int TOTAL_BITS = fqrqs_pkg::TOTAL_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [fqrqs_pkg::THRESH_W-1:0] threshold,
    input  wire logic                           ev_valid,
    output logic                                ev_ready,
    input  wire logic [fqrqs_pkg::SUM_W-1:0]    ev_sum,
    input  wire logic [LEN_W-1:0]               ev_len,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [fqrqs_pkg::OUT_W-1:0]    out_data
);

    localparam int PROD_W = fqrqs_pkg::THRESH_W + LEN_W;
    localparam int CMP_W  = (PROD_W > fqrqs_pkg::SUM_W - 1) ? PROD_W : fqrqs_pkg::SUM_W - 1;

    logic                              out_valid_reg, out_valid_next;
    logic [fqrqs_pkg::SUM_W-1:0]       sum_reg;
    logic [LEN_W-1:0]                  len_reg;
    logic                              low_reg;
    logic [fqrqs_pkg::COUNT_W-1:0]     reads_reg, reads_next;
    logic [fqrqs_pkg::COUNT_W-1:0]     low_reads_reg, low_reads_next;
    logic [TOTAL_BITS-1:0]             tot_sum_reg, tot_sum_next;
    logic [TOTAL_BITS-1:0]             tot_cnt_reg, tot_cnt_next;

    logic                              load;
    logic [PROD_W-1:0]                 limit;
    logic                              is_low;
    logic [fqrqs_pkg::TOTAL_W-1:0]     total_out;
    logic [fqrqs_pkg::TOTAL_W-1:0]     chars_out;
    logic [fqrqs_pkg::LENGTH_W-1:0]    length_out;

    assign ev_ready = !out_valid_reg || out_ready;
    assign load     = ev_valid && ev_ready;

    always_comb
    begin
        limit  = PROD_W'(threshold) * PROD_W'(ev_len);
        is_low = ev_sum[fqrqs_pkg::SUM_W-1]
              || (CMP_W'(ev_sum[fqrqs_pkg::SUM_W-2:0]) <= CMP_W'(limit));

        reads_next     = reads_reg;
        low_reads_next = low_reads_reg;
        tot_sum_next   = tot_sum_reg;
        tot_cnt_next   = tot_cnt_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            reads_next     = reads_reg + 32'd1;
            low_reads_next = is_low ? low_reads_reg + 32'd1 : low_reads_reg;
            tot_sum_next   = tot_sum_reg + TOTAL_BITS'($signed(ev_sum));
            tot_cnt_next   = tot_cnt_reg + TOTAL_BITS'(ev_len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            reads_reg     <= '0;
            low_reads_reg <= '0;
            tot_sum_reg   <= '0;
            tot_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            reads_reg     <= reads_next;
            low_reads_reg <= low_reads_next;
            tot_sum_reg   <= tot_sum_next;
            tot_cnt_reg   <= tot_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= ev_sum;
            len_reg <= ev_len;
            low_reg <= is_low;
        end
    end

    always_comb
    begin
        total_out  = fqrqs_pkg::TOTAL_W'($signed(tot_sum_reg));
        chars_out  = fqrqs_pkg::TOTAL_W'(tot_cnt_reg);
        length_out = fqrqs_pkg::LENGTH_W'(len_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {7'd0, chars_out, total_out, low_reads_reg, reads_reg,
                        low_reg, length_out, sum_reg};

endmodule

`default_nettype wire

@@ src/fastq_read_quality_screen_core.sv @@
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tdata: stream_byte; tlast: end_of_data
// m_axis    out        tdata: one result word per closed record (see port comment)
// cfg       in         cfg_wdata: read threshold, written when cfg_we is high
//
// A new byte is accepted in every cycle while s_axis_tready is high.
// A closed record reaches m_axis through the record register and then the
// threshold compare and counter update.
// Reset clears the line position, the open record and all running counters;
// the threshold returns to 30.
// A stalled m_axis holds its word; one more record may close behind it before
// s_axis_tready drops.

module fastq_read_quality_screen_core #(
    parameter int MAX_READ_LENGTH = fqrqs_pkg::MAX_READ_LENGTH_DEF,
    parameter int TOTAL_BITS      = fqrqs_pkg::TOTAL_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // stream_byte [7:0]
    input  wire logic [fqrqs_pkg::BYTE_W-1:0]   s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // read_quality_sum [23:0], read_length [39:24], read_is_low [40],
    // reads_seen [72:41], low_reads_seen [104:73], quality_total [144:105],
    // quality_chars [184:145], zero [191:185]
    output logic      [fqrqs_pkg::OUT_W-1:0]    m_axis_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [fqrqs_pkg::THRESH_W-1:0] cfg_wdata
);

    localparam int LEN_W = $clog2(MAX_READ_LENGTH + 1);

    logic [fqrqs_pkg::THRESH_W-1:0] threshold_reg, threshold_next;
    logic                           ev_valid;
    logic                           ev_ready;
    logic [fqrqs_pkg::SUM_W-1:0]    ev_sum;
    logic [LEN_W-1:0]               ev_len;

    always_comb
    begin
        threshold_next = cfg_we ? cfg_wdata : threshold_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= fqrqs_pkg::THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    fqrqs_parse #(
        .MAX_READ_LENGTH (MAX_READ_LENGTH),
        .LEN_W           (LEN_W)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev_sum   (ev_sum),
        .ev_len   (ev_len)
    );

    fqrqs_tally #(
        .LEN_W      (LEN_W),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_sum    (ev_sum),
        .ev_len    (ev_len),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_fastq_read_quality_screen_core.sv @@
`timescale 1ns / 1ps

module tb_fastq_read_quality_screen_core;

    localparam int QUIET_LIMIT = 5000;
    localparam int MAX_LEN     = fqrqs_pkg::MAX_READ_LENGTH_DEF;
    localparam int SUM_HI      = 8388607;
    localparam int SUM_LO      = -8388608;

    localparam logic [8:0] LF  = {1'b0, fqrqs_pkg::NEWLINE_BYTE};
    localparam logic [8:0] EOD = 9'h100;

    typedef struct packed {
        logic [6:0]                     zero;
        logic [fqrqs_pkg::TOTAL_W-1:0]  chars;
        logic [fqrqs_pkg::TOTAL_W-1:0]  total;
        logic [fqrqs_pkg::COUNT_W-1:0]  low_reads;
        logic [fqrqs_pkg::COUNT_W-1:0]  reads;
        logic                           is_low;
        logic [fqrqs_pkg::LENGTH_W-1:0] length;
        logic [fqrqs_pkg::SUM_W-1:0]    sum;
    } read_summary_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [fqrqs_pkg::BYTE_W-1:0]   s_axis_tdata  = '0;
    logic                           s_axis_tlast  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b1;
    logic [fqrqs_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                           cfg_we        = 1'b0;
    logic [fqrqs_pkg::THRESH_W-1:0] cfg_wdata     = '0;

    // Shadow copy of the screen state and its threshold.
    logic [fqrqs_pkg::THRESH_W-1:0]     threshold_q    = fqrqs_pkg::THRESHOLD_RESET;
    logic [1:0]                         line_pos       = 2'd0;
    logic                               record_open    = 1'b0;
    logic signed [fqrqs_pkg::SUM_W-1:0] qual_sum       = '0;
    logic [fqrqs_pkg::LENGTH_W-1:0]     qual_len       = '0;
    logic [fqrqs_pkg::COUNT_W-1:0]      read_count     = '0;
    logic [fqrqs_pkg::COUNT_W-1:0]      low_read_count = '0;
    logic [fqrqs_pkg::TOTAL_W-1:0]      sum_total      = '0;
    logic [fqrqs_pkg::TOTAL_W-1:0]      char_total     = '0;
    read_summary_t                      pending_reads[$];

    bit            src_gaps    = 1'b1;
    bit            sink_stalls = 1'b1;
    int            words_sent  = 0;
    int            mismatches  = 0;
    int            quiet_cycles = 0;
    read_summary_t got;
    read_summary_t want;
    string         bad;

    fastq_read_quality_screen_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == fqrqs_pkg::NEWLINE_BYTE);
        return b;
    endfunction

    function automatic void close_read();
        read_summary_t r;
        longint lhs;
        longint rhs;
        lhs = qual_sum;
        rhs = longint'(threshold_q) * longint'(qual_len);
        r.is_low = (lhs <= rhs);
        read_count = read_count + 1;
        if (r.is_low)
            low_read_count = low_read_count + 1;
        sum_total  = sum_total
                   + {{(fqrqs_pkg::TOTAL_W - fqrqs_pkg::SUM_W){qual_sum[fqrqs_pkg::SUM_W-1]}},
                      qual_sum};
        char_total = char_total + qual_len;
        r.zero      = '0;
        r.sum       = qual_sum;
        r.length    = qual_len;
        r.reads     = read_count;
        r.low_reads = low_read_count;
        r.total     = sum_total;
        r.chars     = char_total;
        pending_reads.push_back(r);
        line_pos    = 2'd0;
        record_open = 1'b0;
        qual_sum    = '0;
        qual_len    = '0;
    endfunction

    function automatic void screen_byte(logic [7:0] b, logic last);
        int s;
        record_open = 1'b1;
        if (b == fqrqs_pkg::NEWLINE_BYTE)
        begin
            if (line_pos == fqrqs_pkg::QUAL_LINE)
            begin
                close_read();
                return;
            end
            line_pos = line_pos + 2'd1;
        end
        else if (line_pos == fqrqs_pkg::QUAL_LINE && qual_len < MAX_LEN)
        begin
            s = qual_sum + int'(b) - int'(fqrqs_pkg::PHRED_OFFSET);
            if (s > SUM_HI)
                s = SUM_HI;
            if (s < SUM_LO)
                s = SUM_LO;
            qual_sum = s[fqrqs_pkg::SUM_W-1:0];
            qual_len = qual_len + 16'd1;
        end
        if (last && record_open)
            close_read();
    endfunction

    function automatic string describe(read_summary_t r);
        return $sformatf("sum %0d len %0d low %0b reads %0d low_reads %0d total %0d chars %0d",
            $signed(r.sum), r.length, r.is_low, r.reads, r.low_reads, $signed(r.total),
            r.chars);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        screen_byte(b, last);
        words_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [fqrqs_pkg::THRESH_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        threshold_q = value;
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 8))
        begin
            b = ($urandom_range(0, 5) == 0) ? fqrqs_pkg::NEWLINE_BYTE
                                             : 8'($urandom_range(0, 255));
            send_word(b, $urandom_range(0, 39) == 0);
        end
    endtask

    // One FASTQ record with qualities centered on the current threshold, so that
    // both outcomes of the low test show up. A broken record stops part way.
    task automatic send_record(input bit broken);
        logic [8:0] rec[$];
        int seq_len;
        int qlen;
        int center;
        int jitter;
        int v;
        int r;
        seq_len = $urandom_range(0, 15);
        rec.push_back(9'h040);
        repeat ($urandom_range(0, 6)) rec.push_back({1'b0, text_byte()});
        rec.push_back(LF);
        repeat (seq_len) rec.push_back({1'b0, text_byte()});
        rec.push_back(LF);
        rec.push_back(9'h02B);
        rec.push_back(LF);
        qlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : seq_len;
        jitter = $urandom_range(0, 6);
        center = int'(fqrqs_pkg::PHRED_OFFSET) + int'(threshold_q) + jitter - 3;
        repeat (qlen)
        begin
            if ($urandom_range(0, 9) == 0)
                rec.push_back({1'b0, text_byte()});
            else
            begin
                jitter = $urandom_range(0, 8);
                v = center + jitter - 4;
                if (v > 255)
                    v = 255;
                rec.push_back({1'b0, 8'(v)});
            end
        end
        rec.push_back(LF);
        r = $urandom_range(0, 19);
        if (r == 0)
            rec[rec.size() - 1] = LF | EOD;
        else if (r == 1 && qlen > 0)
        begin
            void'(rec.pop_back());
            rec[rec.size() - 1] = rec[rec.size() - 1] | EOD;
        end
        if (broken)
        begin
            r = $urandom_range(1, rec.size() - 1);
            while (rec.size() > r)
                void'(rec.pop_back());
        end
        foreach (rec[i])
            send_word(rec[i][7:0], rec[i][8]);
    endtask

    task automatic test_directed();
        logic [8:0] steps [24] = '{
            LF, LF, LF, 9'h03F, LF,
            9'h000, LF, 9'h0FF, LF, 9'h080, LF, 9'h0FF, 9'h000, LF,
            LF, LF, LF, LF | EOD,
            9'h041 | EOD,
            LF, LF, LF, 9'h040 | EOD,
            LF | EOD
        };
        foreach (steps[i])
            send_word(steps[i][7:0], steps[i][8]);
    endtask

    // A long quality line of high values, sent back to back.
    task automatic test_long_read();
        wait_idle();
        write_threshold(7'd127);
        src_gaps = 1'b0;
        repeat (3) send_word(fqrqs_pkg::NEWLINE_BYTE, 1'b0);
        repeat (200) send_word(8'($urandom_range(128, 255)), 1'b0);
        send_word(fqrqs_pkg::NEWLINE_BYTE, 1'b0);
        src_gaps = 1'b1;
    endtask

    task automatic test_random_phases(input int total_words);
        int per_phase;
        int start;
        int k;
        per_phase = total_words / 6;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            if (phase == 0)
                write_threshold(7'd0);
            else if (phase == 1)
                write_threshold(7'd127);
            else
                write_threshold(7'($urandom_range(0, 127)));
            src_gaps    = (phase != 2 && phase != 4);
            sink_stalls = (phase != 2);
            start = words_sent;
            while (words_sent - start < per_phase)
            begin
                k = $urandom_range(0, 9);
                if (k == 0)
                    send_noise();
                else
                    send_record(k == 1);
            end
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (sink_stalls && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_reads.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output word with no read pending: %s", describe(got));
            end
            else
            begin
                want = pending_reads.pop_front();
                bad = "";
                if (got.sum !== want.sum)
                    bad = {bad, " read_quality_sum"};
                if (got.length !== want.length)
                    bad = {bad, " read_length"};
                if (got.is_low !== want.is_low)
                    bad = {bad, " read_is_low"};
                if (got.reads !== want.reads)
                    bad = {bad, " reads_seen"};
                if (got.low_reads !== want.low_reads)
                    bad = {bad, " low_reads_seen"};
                if (got.total !== want.total)
                    bad = {bad, " quality_total"};
                if (got.chars !== want.chars)
                    bad = {bad, " quality_chars"};
                if (got.zero !== want.zero)
                    bad = {bad, " padding"};
                if (bad != "")
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch on read %0d:%s", want.reads, bad);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no word moved for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_read();
        test_random_phases(1720);
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
